// ===== rtl/csc_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CORDIC sine/cosine package
// Shared widths, fixed-point constants, arctangent and gain tables, and the
// command word passed from the controller to the datapath.
// -----------------------------------------------------------------------------
package csc_pkg;

   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 5;
   localparam int STEP_W    = 5;
   localparam int GAIN_W    = 30;
   localparam int MAX_ITERS = 24;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd23;
   localparam logic [STEP_W-1:0]  LAST_STEP_MAX = STEP_W'(MAX_ITERS - 1);

   // angles in Q3.29, vector in Q2.30
   localparam logic signed [DATA_W-1:0] PI_Q      = 32'sd1686629713;
   localparam logic signed [DATA_W-1:0] HALF_PI_Q = 32'sd843314857;
   localparam logic signed [DATA_W-1:0] ONE_Q     = 32'sh4000_0000;

   typedef struct packed {
      logic              load;
      logic              rotate;
      logic              scale_lo;
      logic              scale_hi;
      logic              out_load;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] gain_sel;
   } csc_cmd_type;

   // arctan(2^-j) in Q3.29
   function automatic logic signed [DATA_W-1:0] atan_value(input logic [STEP_W-1:0] j);
      logic signed [DATA_W-1:0] v;
      case (j)
         5'd0:    v = 32'sd421657428;
         5'd1:    v = 32'sd248918915;
         5'd2:    v = 32'sd131521918;
         5'd3:    v = 32'sd66762579;
         5'd4:    v = 32'sd33510843;
         5'd5:    v = 32'sd16771758;
         5'd6:    v = 32'sd8387925;
         5'd7:    v = 32'sd4194219;
         5'd8:    v = 32'sd2097141;
         5'd9:    v = 32'sd1048575;
         5'd10:   v = 32'sd524288;
         5'd11:   v = 32'sd262144;
         5'd12:   v = 32'sd131072;
         5'd13:   v = 32'sd65536;
         5'd14:   v = 32'sd32768;
         5'd15:   v = 32'sd16384;
         5'd16:   v = 32'sd8192;
         5'd17:   v = 32'sd4096;
         5'd18:   v = 32'sd2048;
         5'd19:   v = 32'sd1024;
         5'd20:   v = 32'sd512;
         5'd21:   v = 32'sd256;
         5'd22:   v = 32'sd128;
         5'd23:   v = 32'sd64;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // inverse CORDIC gain for (sel + 1) iterations in unsigned Q0.30
   function automatic logic [GAIN_W-1:0] gain_value(input logic [STEP_W-1:0] sel);
      logic [GAIN_W-1:0] g;
      case (sel)
         5'd0:    g = 30'd759250125;
         5'd1:    g = 30'd679093957;
         5'd2:    g = 30'd658817909;
         5'd3:    g = 30'd653730436;
         5'd4:    g = 30'd652457347;
         5'd5:    g = 30'd652138997;
         5'd6:    g = 30'd652059405;
         5'd7:    g = 30'd652039507;
         5'd8:    g = 30'd652034532;
         5'd9:    g = 30'd652033289;
         5'd10:   g = 30'd652032978;
         5'd11:   g = 30'd652032900;
         5'd12:   g = 30'd652032881;
         5'd13:   g = 30'd652032876;
         default: g = 30'd652032874;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/csc_datapath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CORDIC sine/cosine datapath
// Angle fold, shift-add micro-rotation unit, two-pass gain multiply and the
// result register.
// -----------------------------------------------------------------------------
module csc_datapath (
   input  logic                               clock,
   input  logic signed [csc_pkg::DATA_W-1:0]  req_angle,
   input  csc_pkg::csc_cmd_type               cmd,
   output logic signed [csc_pkg::DATA_W-1:0]  rsp_cosine,
   output logic signed [csc_pkg::DATA_W-1:0]  rsp_sine
);
   import csc_pkg::*;

   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                     negate_ff, negate_in;
   logic [DATA_W-1:0]        lo_x_ff, lo_y_ff, res_x_ff, res_y_ff;
   logic signed [DATA_W-1:0] cos_ff, sin_ff;

   logic signed [DATA_W-1:0] dx, dy, at;
   logic [DATA_W-1:0]        mag_x, mag_y;
   logic [GAIN_W-1:0]        gain;
   logic [47:0]              prod_lo_x, prod_lo_y;
   logic [45:0]              prod_hi_x, prod_hi_y;
   logic [46:0]              sum_x, sum_y;

   // fold into plus or minus pi/2
   always_comb begin
      negate_in = 1'b0;
      z_in      = req_angle;
      if (req_angle > HALF_PI_Q) begin
         z_in      = req_angle - PI_Q;
         negate_in = 1'b1;
      end else if (req_angle < -HALF_PI_Q) begin
         z_in      = req_angle + PI_Q;
         negate_in = 1'b1;
      end
   end

   assign dx = y_ff >>> cmd.step;
   assign dy = x_ff >>> cmd.step;
   assign at = atan_value(cmd.step);

   always_comb begin
      if (cmd.load) begin
         x_in = ONE_Q;
         y_in = '0;
      end else if (z_ff < 0) begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
      end else begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
      end
   end

   // gain multiply on magnitudes, truncated toward zero
   assign gain      = gain_value(cmd.gain_sel);
   assign mag_x     = x_ff[DATA_W-1] ? DATA_W'(-x_ff) : DATA_W'(x_ff);
   assign mag_y     = y_ff[DATA_W-1] ? DATA_W'(-y_ff) : DATA_W'(y_ff);
   assign prod_lo_x = mag_x * gain[15:0];
   assign prod_lo_y = mag_y * gain[15:0];
   assign prod_hi_x = mag_x * gain[GAIN_W-1:16];
   assign prod_hi_y = mag_y * gain[GAIN_W-1:16];
   assign sum_x     = 47'(prod_hi_x) + 47'(lo_x_ff);
   assign sum_y     = 47'(prod_hi_y) + 47'(lo_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         negate_ff <= negate_in;
      end else if (cmd.rotate) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= (z_ff < 0) ? z_ff + at : z_ff - at;
      end
      if (cmd.scale_lo) begin
         lo_x_ff <= prod_lo_x[47:16];
         lo_y_ff <= prod_lo_y[47:16];
      end
      if (cmd.scale_hi) begin
         res_x_ff <= sum_x[45:14];
         res_y_ff <= sum_y[45:14];
      end
      if (cmd.out_load) begin
         cos_ff <= (x_ff[DATA_W-1] ^ negate_ff) ? -$signed(res_x_ff) : $signed(res_x_ff);
         sin_ff <= (y_ff[DATA_W-1] ^ negate_ff) ? -$signed(res_y_ff) : $signed(res_y_ff);
      end
   end

   assign rsp_cosine = cos_ff;
   assign rsp_sine   = sin_ff;

endmodule

// ===== rtl/csc_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CORDIC sine/cosine controller
// Sequences load, micro-rotations and gain passes, holds the iteration count
// register and the result valid flag.
// -----------------------------------------------------------------------------
module csc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csc_pkg::COUNT_W-1:0]   csr_data,
   output csc_pkg::csc_cmd_type          cmd
);
   import csc_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      ROTATE,
      SCALE_LO,
      SCALE_HI,
      FINISH
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff;
   logic [STEP_W-1:0]  last_step;
   logic               out_free;

   // zero runs one micro-rotation, large counts saturate
   always_comb begin
      if (count_ff == '0)
         last_step = '0;
      else if (count_ff > COUNT_W'(MAX_ITERS))
         last_step = LAST_STEP_MAX;
      else
         last_step = STEP_W'(count_ff - 1'b1);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.gain_sel = last_step;
      cmd.load     = (state_ff == IDLE) && req_valid;
      cmd.rotate   = (state_ff == ROTATE);
      cmd.scale_lo = (state_ff == SCALE_LO);
      cmd.scale_hi = (state_ff == SCALE_HI);
      cmd.out_load = (state_ff == FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            count_ff <= csr_data;

         // drop the word once taken, raise it when a new one lands
         if (cmd.out_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            IDLE: begin
               step_ff <= '0;
               if (req_valid)
                  state_ff <= ROTATE;
            end
            ROTATE: begin
               if (step_ff == last_step)
                  state_ff <= SCALE_LO;
               else
                  step_ff <= step_ff + 1'b1;
            end
            SCALE_LO: state_ff <= SCALE_HI;
            SCALE_HI: state_ff <= FINISH;
            FINISH: begin
               if (out_free)
                  state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/cordic_sine_cosine_core.sv =====
`timescale 1ns / 1ps
// An accepted angle runs n micro-rotations (n being the iteration count, zero
// counts as one, above 24 as 24), the two gain passes and FINISH, which raises
// rsp_valid once no stalled result is held. New angles stall until IDLE; the
// single shift-add rotation unit does one micro-rotation per cycle.
// Reset (synchronous): controller idle, no result pending, count back to 23.
// -----------------------------------------------------------------------------
// CORDIC sine/cosine core
// Rotation-mode CORDIC giving cosine and sine in Q2.30 of a Q3.29 angle.
// -----------------------------------------------------------------------------
module cordic_sine_cosine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [csc_pkg::DATA_W-1:0]  req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [csc_pkg::DATA_W-1:0]  rsp_cosine,
   output logic signed [csc_pkg::DATA_W-1:0]  rsp_sine,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [csc_pkg::COUNT_W-1:0]        csr_data
);
   import csc_pkg::*;

   csc_cmd_type cmd;

   csc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd)
   );

   csc_datapath u_datapath (
      .clock      (clock),
      .req_angle  (req_angle),
      .cmd        (cmd),
      .rsp_cosine (rsp_cosine),
      .rsp_sine   (rsp_sine)
   );

endmodule

// ===== tb/cordic_sine_cosine_check.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CORDIC sine/cosine checker
// Watches the angle, result and count channels. For every accepted angle it
// works out cosine and sine with its own fixed-point rotation-mode model. It
// then compares each result word, field by field, with the oldest prediction.
// -----------------------------------------------------------------------------
module cordic_sine_cosine_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [csc_pkg::DATA_W-1:0] req_angle,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [csc_pkg::DATA_W-1:0] rsp_cosine,
   input  logic signed [csc_pkg::DATA_W-1:0] rsp_sine,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [csc_pkg::COUNT_W-1:0]       csr_data,
   output int                                mismatch_count,
   output int                                pending_results
);
   import csc_pkg::*;

   localparam int W             = DATA_W;
   localparam int MAX_ROTATIONS = 24;
   localparam int ANGLE_FRAC    = 29;
   localparam int VECTOR_FRAC   = 30;
   localparam int REPORT_CAP    = 40;

   localparam logic [COUNT_W-1:0] RESET_ROTATIONS = 5'd23;

   localparam longint unsigned FIVE_POW_14 = 64'd6103515625;
   localparam longint unsigned PI_E14      = 64'd314159265358979;
   localparam longint unsigned HALF_PI_E14 = 64'd157079632679490;

   typedef struct packed {
      logic signed [W-1:0] angle;
      logic signed [W-1:0] cosine;
      logic signed [W-1:0] sine;
   } trig_word_type;

   trig_word_type      expected_q[$];
   logic [COUNT_W-1:0] rotations;

   // arctan(2^-j) in units of 1e-14
   function automatic longint unsigned atan_e14(input int j);
      case (j)
         0:       return 64'd78539816339745;
         1:       return 64'd46364760900081;
         2:       return 64'd24497866312686;
         3:       return 64'd12435499454676;
         4:       return 64'd6241880999596;
         5:       return 64'd3123983343027;
         6:       return 64'd1562372862048;
         7:       return 64'd781234106010;
         8:       return 64'd390623013197;
         9:       return 64'd195312251648;
         10:      return 64'd97656218956;
         11:      return 64'd48828121119;
         12:      return 64'd24414062015;
         13:      return 64'd12207031189;
         14:      return 64'd6103515617;
         15:      return 64'd3051757812;
         16:      return 64'd1525878906;
         17:      return 64'd762939453;
         18:      return 64'd381469727;
         19:      return 64'd190734863;
         20:      return 64'd95367432;
         21:      return 64'd47683716;
         22:      return 64'd23841858;
         23:      return 64'd11920929;
         default: return 64'd0;
      endcase
   endfunction

   // product of 1/sqrt(1 + 2^-2i) over j + 1 rotations, units of 1e-14
   function automatic longint unsigned gain_e14(input int j);
      case (j)
         0:       return 64'd70710678118655;
         1:       return 64'd63245553203368;
         2:       return 64'd61357199107790;
         3:       return 64'd60883391251775;
         4:       return 64'd60764825625617;
         5:       return 64'd60735177014130;
         6:       return 64'd60727764409353;
         7:       return 64'd60725911229889;
         8:       return 64'd60725447933256;
         9:       return 64'd60725332108988;
         10:      return 64'd60725303152913;
         11:      return 64'd60725295913894;
         12:      return 64'd60725294104140;
         13:      return 64'd60725293651701;
         14:      return 64'd60725293538591;
         15:      return 64'd60725293510314;
         16:      return 64'd60725293503245;
         17:      return 64'd60725293501477;
         18:      return 64'd60725293501035;
         19:      return 64'd60725293500925;
         20:      return 64'd60725293500897;
         21:      return 64'd60725293500890;
         22:      return 64'd60725293500889;
         default: return 64'd60725293500888;
      endcase
   endfunction

   // d * 1e-14 with frac fraction bits, rounded half up; split the shift to stay in 64 bits
   function automatic longint unsigned e14_to_fixed(input longint unsigned d, input int frac);
      int                s1, s2;
      longint unsigned   r, q, rem;
      s1  = (frac - 14) / 2;
      s2  = frac - 14 - s1;
      r   = d << s1;
      q   = r / FIVE_POW_14;
      rem = r % FIVE_POW_14;
      return (q << s2) + (((rem << s2) + FIVE_POW_14 / 2) / FIVE_POW_14);
   endfunction

   // v * k / 2^30, truncated toward zero
   function automatic logic signed [W-1:0] apply_gain(input logic signed [W-1:0] v,
                                                       input longint unsigned k);
      longint              wide;
      longint unsigned     mag;
      logic signed [W-1:0] part;
      wide = v;
      mag  = (wide < 0) ? -wide : wide;
      part = W'((mag * k) >> VECTOR_FRAC);
      return (wide < 0) ? -part : part;
   endfunction

   function automatic trig_word_type predict_sin_cos(input logic signed [W-1:0] angle,
                                                     input logic [COUNT_W-1:0]  count);
      trig_word_type       r;
      int                  steps, j;
      longint              folded, pi_q, half_q;
      longint unsigned     k;
      logic signed [W-1:0] x, y, z, dx, dy, step_atan;
      logic                flip;
      steps = count;
      if (steps == 0)
         steps = 1;
      if (steps > MAX_ROTATIONS)
         steps = MAX_ROTATIONS;
      pi_q   = e14_to_fixed(PI_E14, ANGLE_FRAC);
      half_q = e14_to_fixed(HALF_PI_E14, ANGLE_FRAC);
      folded = angle;
      flip   = 1'b0;
      // fold by pi into the right half plane; the bound itself stays put
      if (folded > half_q) begin
         folded = folded - pi_q;
         flip   = 1'b1;
      end else if (folded < -half_q) begin
         folded = folded + pi_q;
         flip   = 1'b1;
      end
      z = folded[W-1:0];
      x = 1 << VECTOR_FRAC;
      y = '0;
      for (j = 0; j < steps; j++) begin
         dx        = y >>> j;
         dy        = x >>> j;
         step_atan = W'(e14_to_fixed(atan_e14(j), ANGLE_FRAC));
         // a zero residual turns the positive way
         if (z < 0) begin
            x = x + dx;
            y = y - dy;
            z = z + step_atan;
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - step_atan;
         end
      end
      k = e14_to_fixed(gain_e14(steps - 1), VECTOR_FRAC);
      x = apply_gain(x, k);
      y = apply_gain(y, k);
      if (flip) begin
         x = -x;
         y = -y;
      end
      r.angle  = angle;
      r.cosine = x;
      r.sine   = y;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP)
         $display("[%0t] %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      trig_word_type due;
      if (reset) begin
         rotations = RESET_ROTATIONS;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            rotations = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result cos %h sin %h with no angle outstanding",
                                         rsp_cosine, rsp_sine));
            end else begin
               due = expected_q.pop_front();
               if (rsp_cosine !== due.cosine)
                  report_mismatch($sformatf("angle %h: cosine %h, predicted %h",
                                            due.angle, rsp_cosine, due.cosine));
               if (rsp_sine !== due.sine)
                  report_mismatch($sformatf("angle %h: sine %h, predicted %h",
                                            due.angle, rsp_sine, due.sine));
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(predict_sin_cos(req_angle, rotations));
      end
      pending_results = expected_q.size();
   end

endmodule

// ===== tb/cordic_sine_cosine_core_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// CORDIC sine/cosine core testbench
// Drives corner angles and then random angles through the core over a range
// of iteration counts, with random gaps and stalls on both channels, long
// result hold-offs and a full drain mid-stream. Checking is left to the
// checker instance; this module makes stimulus and gives the verdict.
// -----------------------------------------------------------------------------
module cordic_sine_cosine_core_test;
   import csc_pkg::*;

   localparam int DIRECT_COUNT  = 17;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 111;
   localparam int SINK_HOLD     = 300;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 500000;

   localparam logic signed [DATA_W-1:0] QUARTER_PI = 32'sd421657428;
   localparam logic signed [DATA_W-1:0] ONE_RADIAN = 32'sh2000_0000;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic signed [DATA_W-1:0] req_angle  = '0;
   logic                     rsp_stall  = 1'b0;
   logic                     csr_valid  = 1'b0;
   logic [COUNT_W-1:0]       csr_data   = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic                     csr_ready;
   logic signed [DATA_W-1:0] rsp_cosine;
   logic signed [DATA_W-1:0] rsp_sine;
   int                       mismatch_count;
   int                       pending_results;

   bit steady     = 1'b0;
   int hold_asked = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cordic_sine_cosine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_cosine (rsp_cosine),
      .rsp_sine   (rsp_sine),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   cordic_sine_cosine_check trig_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_angle       (req_angle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cosine      (rsp_cosine),
      .rsp_sine        (rsp_sine),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   function automatic logic signed [DATA_W-1:0] corner_angle(input int idx);
      case (idx)
         0:       return '0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return 32'sh7FFF_FFFF;
         4:       return 32'sh8000_0000;
         // exactly on plus or minus pi/2: no fold
         5:       return HALF_PI_Q;
         6:       return -HALF_PI_Q;
         7:       return HALF_PI_Q + 32'sd1;
         8:       return -HALF_PI_Q - 32'sd1;
         9:       return PI_Q;
         10:      return -PI_Q;
         // residual hits zero after the first turn
         11:      return QUARTER_PI;
         12:      return -QUARTER_PI;
         13:      return 32'sh5555_5555;
         14:      return 32'shAAAA_AAAA;
         15:      return ONE_RADIAN;
         default: return -ONE_RADIAN;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_angle();
      int unsigned              sel;
      logic signed [DATA_W-1:0] offset;
      sel    = $urandom_range(0, 19);
      offset = $urandom_range(0, 32);
      offset = offset - 32'sd16;
      if (sel < 13)
         return $urandom;
      if (sel < 16)
         return ($urandom_range(0, 1) ? HALF_PI_Q : -HALF_PI_Q) + offset;
      if (sel < 18)
         return offset * 4;
      return corner_angle($urandom_range(0, DIRECT_COUNT - 1));
   endfunction

   function automatic logic [COUNT_W-1:0] phase_count(input int p);
      case (p)
         0:       return 5'd1;
         1:       return 5'd24;
         2:       return 5'd0;
         3:       return 5'd31;
         4:       return 5'd2;
         5:       return 5'd25;
         6:       return 5'd16;
         default: return COUNT_W'($urandom_range(0, 31));
      endcase
   endfunction

   // called just after the clock rises; returns once the core has taken the word
   task automatic send_angle(input logic signed [DATA_W-1:0] angle);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic await_drain();
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic set_rotations(input logic [COUNT_W-1:0] count);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // result side: random stall per word, and a long hold-off when asked
   initial begin : result_sink
      int gap;
      int served;
      served = 0;
      while (reset) @(posedge clock);
      forever begin
         if (served < hold_asked) begin
            gap    = SINK_HOLD;
            served = served + 1;
         end else if (steady) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 3);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("cordic_sine_cosine_core: mismatch");
      $finish;
   end

   initial begin : stimulus
      int p, i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < DIRECT_COUNT; i++)
         send_angle(corner_angle(i));
      req_valid <= 1'b0;
      await_drain();
      for (p = 0; p < PHASES; p++) begin
         set_rotations(phase_count(p));
         steady = (p % 4 == 1);
         if (p == 2 || p == 9)
            hold_asked++;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 5 && i == PHASE_ITEMS / 2) begin
               // hold the angle stream until every result is home
               req_valid <= 1'b0;
               await_drain();
            end
            send_angle(pick_angle());
         end
         req_valid <= 1'b0;
         await_drain();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cordic_sine_cosine_core: match");
      end else begin
         $display("cordic_sine_cosine_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/csc_pkg.sv
rtl/csc_datapath.sv
rtl/csc_ctrl.sv
rtl/cordic_sine_cosine_core.sv
tb/cordic_sine_cosine_check.sv
tb/cordic_sine_cosine_core_test.sv
